[sv/pba_pkg.sv]
// Shared types and constants for the page bitmap allocator.
// Used by page_bitmap_allocator; no dependencies.
package pba_pkg;

  localparam int PAGE_COUNT_DEF = 4096;
  localparam int ADDR_W         = 48;
  localparam int LEN_W          = 48;
  localparam int PAGE_SHIFT     = 12;
  localparam int PAGE_IDX_W     = ADDR_W - PAGE_SHIFT;
  // Page count of a byte length: one extra bit for the round-up carry
  localparam int PAGES_W        = LEN_W - PAGE_SHIFT + 1;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_RESERVE = 2'd2,
    ACT_TEST    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_TEST
  } state_t;

endpackage

[sv/pba_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/page_bitmap_allocator.sv]
// Page bitmap allocator top level: sequencer, scan logic and the page map RAM.
// Depends on pba_pkg and pba_ram.
//
// Usage: the block keeps one used/free bit per 4096-byte page in a 1-bit-wide
// RAM of PAGE_COUNT entries. A command is transferred on a rising edge with
// start high and busy low; in_action selects allocate, release region,
// reserve region or test page. Every command produces exactly one result,
// shown for one cycle with out_valid high. The receiver cannot stall, so a
// result is never held and the next command may be transferred in the same
// cycle that the previous result is shown.
// Steps, one RAM access per cycle on the single read and write ports:
//   allocate: the map is read from page 0 up to the last page of the first
//     fitting run, then each page of the run is marked used and the result
//     is shown. A length over the map errors without a scan.
//   release/reserve: each page of the region inside the map is written.
//   test: the page is read from the RAM; a page beyond the map is not read.
// Reset: a clearing pass marks every page used; busy stays high during the
// pass and no command is taken.
module page_bitmap_allocator #(
  parameter int PAGE_COUNT = pba_pkg::PAGE_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_action,
  input  logic [pba_pkg::ADDR_W-1:0]  in_address,
  input  logic [pba_pkg::LEN_W-1:0]   in_length,
  input  logic                        in_failed_grant,
  output logic                        out_valid,
  output logic                        out_error,
  output logic [pba_pkg::ADDR_W-1:0]  out_granted_address,
  output logic [pba_pkg::LEN_W-1:0]   out_granted_length,
  output logic                        out_page_used
);

  import pba_pkg::*;

  localparam int CW = $clog2(PAGE_COUNT + 1);
  localparam int AW = $clog2(PAGE_COUNT);
  localparam logic [CW-1:0] PC_C   = CW'(PAGE_COUNT);
  localparam logic [CW-1:0] LAST_C = CW'(PAGE_COUNT - 1);
  localparam logic [AW-1:0] LAST_A = AW'(PAGE_COUNT - 1);

  state_t state_r, state_nxt;

  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     end_r, end_nxt;
  logic [CW-1:0]     scan_r, scan_nxt;
  logic [AW-1:0]     chk_r, chk_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [CW-1:0]     run_r, run_nxt;
  logic [CW-1:0]     pages_r, pages_nxt;
  logic              mark_bit_r, mark_bit_nxt;
  logic [ADDR_W-1:0] ga_r, ga_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_error_r, out_error_nxt;
  logic [ADDR_W-1:0] out_ga_r, out_ga_nxt;
  logic [LEN_W-1:0]  out_gl_r, out_gl_nxt;
  logic              out_used_r, out_used_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic              ram_rdata;

  logic                  accept;
  logic [PAGE_IDX_W-1:0] page;
  logic [PAGES_W-1:0]    pages;
  logic                  too_long;
  logic                  page_in_map;
  logic                  release_nop;
  logic [CW:0]           reg_sum;
  logic [CW-1:0]         reg_end;
  logic [CW-1:0]         run_inc;
  logic [CW-1:0]         chk_end;
  logic [CW-1:0]         run_start;
  logic                  found;
  logic                  scan_fail;
  logic                  mark_go;
  logic                  clr_last;

  // Command decode
  assign accept      = start && !busy;
  assign page        = in_address[ADDR_W-1:PAGE_SHIFT];
  assign pages       = PAGES_W'(in_length[LEN_W-1:PAGE_SHIFT])
                     + PAGES_W'(|in_length[PAGE_SHIFT-1:0]);
  assign too_long    = pages > PAGES_W'(PAGE_COUNT);
  assign page_in_map = page < PAGE_IDX_W'(PAGE_COUNT);
  assign release_nop = (in_action == ACT_RELEASE) && in_failed_grant;

  // Clip the region end to the map
  assign reg_sum = {1'b0, page[CW-1:0]} + {1'b0, pages[CW-1:0]};
  assign reg_end = (reg_sum > {1'b0, PC_C}) ? PC_C : reg_sum[CW-1:0];

  // Free-run scan on the page returned by the RAM
  assign run_inc   = run_r + CW'(1);
  assign chk_end   = CW'(chk_r) + CW'(1);
  assign run_start = chk_end - pages_r;
  assign found     = chk_vld_r && !ram_rdata && (run_inc >= pages_r);
  assign scan_fail = chk_vld_r && !found && (chk_r == LAST_A);

  assign mark_go  = idx_r < end_r;
  assign clr_last = idx_r == LAST_C;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_ALLOC: begin
              if (!too_long) state_nxt = ST_SCAN;
            end
            ACT_RELEASE, ACT_RESERVE: begin
              if (!release_nop && !too_long) state_nxt = ST_MARK;
            end
            ACT_TEST: begin
              if (page_in_map) state_nxt = ST_TEST;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (found) begin
          state_nxt = ST_MARK;
        end else if (scan_fail) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MARK: begin
        if (!mark_go) state_nxt = ST_IDLE;
      end
      ST_TEST: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, RAM control and result
  always_comb begin
    idx_nxt       = idx_r;
    end_nxt       = end_r;
    scan_nxt      = scan_r;
    chk_nxt       = chk_r;
    chk_vld_nxt   = chk_vld_r;
    run_nxt       = run_r;
    pages_nxt     = pages_r;
    mark_bit_nxt  = mark_bit_r;
    ga_nxt        = ga_r;
    len_nxt       = len_r;
    out_valid_nxt = 1'b0;
    out_error_nxt = out_error_r;
    out_ga_nxt    = out_ga_r;
    out_gl_nxt    = out_gl_r;
    out_used_nxt  = out_used_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[AW-1:0];
    ram_wdata     = mark_bit_r;
    ram_raddr     = in_address[PAGE_SHIFT +: AW];
    case (state_r)
      ST_CLEAR: begin
        // Mark every page used after reset
        ram_we    = 1'b1;
        ram_wdata = 1'b1;
        idx_nxt   = idx_r + CW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          len_nxt = in_length;
          case (in_action)
            ACT_ALLOC: begin
              if (too_long) begin
                out_valid_nxt = 1'b1;
                out_error_nxt = 1'b1;
                out_ga_nxt    = '0;
                out_gl_nxt    = in_length;
                out_used_nxt  = 1'b0;
              end else begin
                scan_nxt    = '0;
                chk_vld_nxt = 1'b0;
                run_nxt     = '0;
                pages_nxt   = pages[CW-1:0];
              end
            end
            ACT_RELEASE, ACT_RESERVE: begin
              if (release_nop || too_long) begin
                out_valid_nxt = 1'b1;
                out_error_nxt = !release_nop;
                out_ga_nxt    = '0;
                out_gl_nxt    = in_length;
                out_used_nxt  = 1'b0;
              end else begin
                idx_nxt      = page_in_map ? page[CW-1:0] : '0;
                end_nxt      = page_in_map ? reg_end : '0;
                mark_bit_nxt = in_action == ACT_RESERVE;
                ga_nxt       = '0;
              end
            end
            ACT_TEST: begin
              // Pages beyond the map read as used
              if (!page_in_map) begin
                out_valid_nxt = 1'b1;
                out_error_nxt = 1'b0;
                out_ga_nxt    = '0;
                out_gl_nxt    = in_length;
                out_used_nxt  = 1'b1;
              end
            end
            default: len_nxt = in_length;
          endcase
        end
      end
      ST_SCAN: begin
        // Issue the next read while checking the page that came back
        ram_raddr = scan_r[AW-1:0];
        if (scan_r < PC_C) begin
          chk_vld_nxt = 1'b1;
          chk_nxt     = scan_r[AW-1:0];
          scan_nxt    = scan_r + CW'(1);
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (chk_vld_r) begin
          run_nxt = ram_rdata ? '0 : run_inc;
        end
        if (found) begin
          idx_nxt      = run_start;
          end_nxt      = chk_end;
          mark_bit_nxt = 1'b1;
          ga_nxt       = ADDR_W'(run_start) << PAGE_SHIFT;
        end else if (scan_fail) begin
          out_valid_nxt = 1'b1;
          out_error_nxt = 1'b1;
          out_ga_nxt    = '0;
          out_gl_nxt    = len_r;
          out_used_nxt  = 1'b0;
        end
      end
      ST_MARK: begin
        // Write one page a cycle until the end of the run or region
        if (mark_go) begin
          ram_we  = 1'b1;
          idx_nxt = idx_r + CW'(1);
        end else begin
          out_valid_nxt = 1'b1;
          out_error_nxt = 1'b0;
          out_ga_nxt    = ga_r;
          out_gl_nxt    = len_r;
          out_used_nxt  = 1'b0;
        end
      end
      ST_TEST: begin
        out_valid_nxt = 1'b1;
        out_error_nxt = 1'b0;
        out_ga_nxt    = '0;
        out_gl_nxt    = len_r;
        out_used_nxt  = ram_rdata;
      end
      default: out_valid_nxt = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    end_r       <= end_nxt;
    scan_r      <= scan_nxt;
    chk_r       <= chk_nxt;
    run_r       <= run_nxt;
    pages_r     <= pages_nxt;
    mark_bit_r  <= mark_bit_nxt;
    ga_r        <= ga_nxt;
    len_r       <= len_nxt;
    out_error_r <= out_error_nxt;
    out_ga_r    <= out_ga_nxt;
    out_gl_r    <= out_gl_nxt;
    out_used_r  <= out_used_nxt;
  end

  // Page map storage
  pba_ram #(
    .WIDTH (1),
    .DEPTH (PAGE_COUNT)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy                = state_r != ST_IDLE;
  assign out_valid           = out_valid_r;
  assign out_error           = out_error_r;
  assign out_granted_address = out_ga_r;
  assign out_granted_length  = out_gl_r;
  assign out_page_used       = out_used_r;

endmodule
